// File: rtl/core/esc_pkg.sv
`default_nettype none
package esc_pkg;

	localparam int DEF_MAX_LEN    = 1024;
	localparam int DEF_VALUE_BITS = 16;

	localparam int CMD_W    = 2;
	localparam int ELEM_W   = 16;
	localparam int TARGET_W = 26;
	localparam int COUNT_W  = 20;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// request command codes
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [ELEM_W-1:0]   element_value;
		logic [TARGET_W-1:0] target_sum;
	} req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] segment_count;
		logic               truncated;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic append;
		logic clear;
		logic start;
		logic step;
		logic load_out;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
		logic out_busy;
	} dp_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/exact_sum_segment_counter.sv
`default_nettype none
// channel  | direction | handshake               | payload
// request  | in        | req_valid / req_ready   | req (command, element_value, target_sum)
// response | out       | rsp_valid / rsp_ready   | rsp (segment_count, truncated)
//
// append and clear requests are taken only in the idle state; unused command codes are taken and dropped
// a query walks two pointers over the n stored elements: both walk pointers
// share one two-read-port prefix sum store and only one of them moves per cycle
// reset clears length and overflow flag; the store itself needs no clearing pass
// a finished result sits in the response register, so new requests are taken
// while it waits; only a second query finishing before it is taken stalls
module exact_sum_segment_counter #(
	parameter int MAX_LEN    = esc_pkg::DEF_MAX_LEN,
	parameter int VALUE_BITS = esc_pkg::DEF_VALUE_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  esc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output esc_pkg::rsp_t rsp
);
	import esc_pkg::*;

	// command and status between sequencer and datapath
	ctl_cmd_t cmd;
	dp_sts_t  sts;

	// sequencer: takes requests, runs the pointer walk, hands off the result
	esc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_command (req.command),
		.sts         (sts),
		.req_ready   (req_ready),
		.cmd         (cmd)
	);

	// datapath: prefix sum store, two walk pointers, match run counter, result register
	esc_dp #(
		.MAX_LEN    (MAX_LEN),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// File: rtl/core/esc_ctrl.sv
`default_nettype none
module esc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_command,
	input  esc_pkg::dp_sts_t  sts,
	output logic              req_ready,
	output esc_pkg::ctl_cmd_t cmd
);
	import esc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   rdy_q;
	logic   accept;

	assign req_ready = rdy_q;
	assign accept    = req_valid && rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdy_q   <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && req_command == CMD_QUERY) begin
						state_q <= ST_RUN;
						rdy_q   <= 1'b0;
					end
				end
				ST_RUN: begin
					if (sts.last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					rdy_q   <= 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.append   = accept && (req_command == CMD_APPEND);
		cmd.clear    = accept && (req_command == CMD_CLEAR);
		cmd.start    = accept && (req_command == CMD_QUERY);
		cmd.step     = (state_q == ST_RUN);
		cmd.load_out = (state_q == ST_DONE) && !sts.out_busy;
	end

endmodule
`default_nettype wire

// File: rtl/core/esc_dp.sv
`default_nettype none
module esc_dp #(
	parameter int MAX_LEN    = esc_pkg::DEF_MAX_LEN,
	parameter int VALUE_BITS = esc_pkg::DEF_VALUE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  esc_pkg::ctl_cmd_t cmd,
	input  esc_pkg::req_t     req,
	input  logic              rsp_ready,
	output esc_pkg::dp_sts_t  sts,
	output logic              rsp_valid,
	output esc_pkg::rsp_t     rsp
);
	import esc_pkg::*;

	localparam int LW   = $clog2(MAX_LEN + 1);
	localparam int PTRW = $clog2(MAX_LEN + 2);
	localparam int AW   = $clog2(MAX_LEN);
	localparam int EB   = (VALUE_BITS < ELEM_W) ? VALUE_BITS : ELEM_W;
	localparam int PW   = EB + LW;
	localparam int KW   = ((PW > TARGET_W) ? PW : TARGET_W) + 1;
	localparam int CW   = 2 * PTRW + 1;
	localparam int RW   = (CW > COUNT_W) ? CW : COUNT_W + 1;

	// prefix sum store: entry k holds the sum of elements 0..k
	logic [PW-1:0] mem [MAX_LEN];

	logic [LW-1:0]       len_q;
	logic                ovf_q;
	logic [PW-1:0]       tail_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic [TARGET_W-1:0] tgt_q;
	logic [PTRW-1:0]     a_q;
	logic [PTRW-1:0]     b_q;
	logic [PTRW-1:0]     run_q;
	logic [PW-1:0]       cur_a_q;
	logic [PW-1:0]       cur_b_q;
	logic [PW-1:0]       rd_a_q;
	logic [PW-1:0]       rd_b_q;
	logic [KW-1:0]       last_key_q;
	logic                have_last_q;
	logic [CW-1:0]       total_q;

	logic                full;
	logic [PW-1:0]       elem;
	logic [PTRW-1:0]     n_ptr;
	logic [PTRW-1:0]     a_inc;
	logic [PTRW-1:0]     b_inc;
	logic                a_ok;
	logic [KW-1:0]       a_key;
	logic [KW-1:0]       b_key;
	logic                take_a;
	logic [AW-1:0]       addr_a;
	logic [AW-1:0]       addr_b;
	logic [CW-1:0]       dup;
	logic [CW-1:0]       pairs;
	logic [RW-1:0]       res_w;
	logic                sat;

	assign full  = (len_q == LW'(MAX_LEN));
	assign elem  = PW'(req.element_value[EB-1:0]);
	assign n_ptr = PTRW'(len_q);
	assign a_inc = a_q + 1'b1;
	assign b_inc = b_q + 1'b1;
	assign a_ok  = (a_q <= n_ptr);
	assign a_key = KW'(cur_a_q) + KW'(tgt_q);
	assign b_key = KW'(cur_b_q);

	// ties go to the shifted side so a whole run is counted before it is matched
	assign take_a = a_ok && (a_key <= b_key);

	// read one ahead of each pointer
	always_comb begin
		if (cmd.start) begin
			addr_a = '0;
			addr_b = '0;
		end else begin
			addr_a = (cmd.step && take_a)  ? a_inc[AW-1:0] : a_q[AW-1:0];
			addr_b = (cmd.step && !take_a) ? b_inc[AW-1:0] : b_q[AW-1:0];
		end
	end

	// zero target: sum of squared run lengths counts each index with itself and both orders
	assign dup   = total_q - CW'(n_ptr) - CW'(1);
	assign pairs = (tgt_q == '0) ? {1'b0, dup[CW-1:1]} : total_q;
	assign res_w = RW'(pairs);
	assign sat   = (res_w > RW'(COUNT_MAX));

	assign sts.last     = cmd.step && !take_a && (b_q == n_ptr);
	assign sts.out_busy = rsp_valid_q && !rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ovf_q       <= 1'b0;
			tail_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				len_q  <= '0;
				ovf_q  <= 1'b0;
				tail_q <= '0;
			end else if (cmd.append) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					len_q  <= len_q + 1'b1;
					tail_q <= tail_q + elem;
				end
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append && !full) begin
			mem[len_q[AW-1:0]] <= tail_q + elem;
		end
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			tgt_q       <= req.target_sum;
			a_q         <= '0;
			b_q         <= '0;
			cur_a_q     <= '0;
			cur_b_q     <= '0;
			run_q       <= '0;
			last_key_q  <= '0;
			have_last_q <= 1'b0;
			total_q     <= '0;
		end else if (cmd.step) begin
			if (take_a) begin
				a_q         <= a_inc;
				cur_a_q     <= rd_a_q;
				run_q       <= (have_last_q && a_key == last_key_q) ? run_q + 1'b1 : PTRW'(1);
				last_key_q  <= a_key;
				have_last_q <= 1'b1;
			end else begin
				b_q     <= b_inc;
				cur_b_q <= rd_b_q;
				if (have_last_q && last_key_q == b_key) begin
					total_q <= total_q + CW'(run_q);
				end
			end
		end
		if (cmd.load_out) begin
			rsp_q.segment_count <= sat ? COUNT_MAX : res_w[COUNT_W-1:0];
			rsp_q.truncated     <= ovf_q;
		end
	end

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (a_q <= n_ptr + 1'b1))
		else $error("shifted pointer ran past the sequence");

	b_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (b_q <= n_ptr))
		else $error("prefix pointer ran past the sequence");

	full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.append && full && !cmd.clear) |=> (ovf_q && len_q == $past(len_q)))
		else $error("append to a full store changed the length");

	out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp_valid_q || rsp_ready))
		else $error("result overwrote one not yet taken");

	run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !take_a && have_last_q) |-> (run_q != '0))
		else $error("match counted with an empty run");

endmodule
`default_nettype wire
